[hdl/rsmd5_pkg.sv]
// ============================================================================
// rsmd5_pkg: shared constants and functions for the record-stream MD5 block
// Round constants, shift amounts, message word selection and byte swapping.
// ============================================================================
package rsmd5_pkg;

    localparam int RecordBytes = 25;
    localparam int DigestBytes = 16;
    localparam int RecordWords = 6;

    localparam logic [1:0] REQ_REGISTER   = 2'd0;
    localparam logic [1:0] REQ_UNREGISTER = 2'd1;
    localparam logic [1:0] REQ_MESSAGE    = 2'd2;
    localparam logic [1:0] REQ_TRANSACT   = 2'd3;

    localparam logic [127:0] CHAIN_INIT = {32'h10325476, 32'h98badcfe,
                                           32'hefcdab89, 32'h67452301};

    typedef struct packed {
        logic start;
        logic busy;
    } rsmd5_rnd_ctl_t;

    function automatic logic [31:0] md_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
            6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
            6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
            6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md_s(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
            4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
            4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
            default: s = 5'd7;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] md_g(input logic [5:0] i);
        logic [3:0] g;
        case (i[5:4])
            2'd0: g = i[3:0];
            2'd1: g = 4'((5 * i[3:0]) + 1);
            2'd2: g = 4'((3 * i[3:0]) + 5);
            default: g = 4'(7 * i[3:0]);
        endcase
        return g;
    endfunction

    // Byte-swap a 32-bit word (chain word to output byte order)
    function automatic logic [31:0] bswap(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage

[hdl/record_stream_md5_digest_unit.sv]
// ============================================================================
// record_stream_md5_digest_unit: running MD5 over 25-byte message records
// Packs each message record into a 64-byte block buffer, compresses full
// blocks with a shared round unit, and pads and finishes on the last item.
// ============================================================================
// Usage: items enter on s_valid/s_ready. Register and unregister items add
// no record bytes. A message or transaction item writes its 25 record
// bytes into the block buffer one byte a cycle, pausing while a full
// buffer is compressed: the round unit runs 64 rounds after a setup state
// and then folds the result into the chain. On any item with s_last_item
// set, the block then writes padding and the bit length a byte a cycle,
// pausing likewise, runs one or two more compressions, then presents one
// result on m_valid/m_ready and resets its running state. The buffer has
// a single-byte write port and the round unit does one round per cycle.
// s_ready is low for the whole of an item and while a result waits; a
// stalled receiver holds the result and the input stays blocked.
// Synchronous active-low reset returns the block to the MD5 initial state
// with no buffered data and no pending result.
// ============================================================================
module record_stream_md5_digest_unit import rsmd5_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [31:0] s_writer_system,
    input  logic [31:0] s_writer_local,
    input  logic [31:0] s_writer_serial,
    input  logic [31:0] s_write_seconds,
    input  logic [31:0] s_write_nanos,
    input  logic [31:0] s_sequence_number,
    input  logic        s_has_instance,
    input  logic        s_instance_no_writers,
    input  logic        s_last_item,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_digest_flags,
    output logic [31:0] m_sample_count,
    output logic [63:0] m_digest_high,
    output logic [63:0] m_digest_low
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_REC   = 4'd1;
    localparam logic [3:0] ST_CMP   = 4'd2;
    localparam logic [3:0] ST_CWAIT = 4'd3;
    localparam logic [3:0] ST_CHECK = 4'd4;
    localparam logic [3:0] ST_PAD   = 4'd5;
    localparam logic [3:0] ST_LEN   = 4'd6;
    localparam logic [3:0] ST_OUT   = 4'd7;

    // Where to resume after a compression
    localparam logic [1:0] AFT_REC  = 2'd0;
    localparam logic [1:0] AFT_PAD  = 2'd1;
    localparam logic [1:0] AFT_LEN  = 2'd2;

    logic [3:0]   state_reg, state_next;
    logic [199:0] rec_reg;
    logic         last_reg;
    logic [4:0]   cnt_reg, cnt_next;
    logic [5:0]   fill_reg, fill_next;
    logic [60:0]  total_reg, total_next;
    logic [31:0]  count_reg, count_next;
    logic [127:0] chain_reg;
    logic [1:0]   after_reg, after_next;
    logic [63:0]  bits_reg;
    logic         pad_first_reg;

    logic         wr_en;
    logic [7:0]   wr_byte;
    logic [31:0]  mem [0:15];
    logic [31:0]  m_word;
    logic [3:0]   m_index;
    logic         rnd_done;
    logic [127:0] chain_new;
    rsmd5_rnd_ctl_t rctl;
    logic         acc;

    assign s_ready = (state_reg == ST_IDLE);
    assign acc     = s_valid && s_ready;

    // Block buffer: byte-lane writes, registered word read for the round unit
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            case (fill_reg[1:0])
                2'd0: mem[fill_reg[5:2]][7:0]   <= wr_byte;
                2'd1: mem[fill_reg[5:2]][15:8]  <= wr_byte;
                2'd2: mem[fill_reg[5:2]][23:16] <= wr_byte;
                default: mem[fill_reg[5:2]][31:24] <= wr_byte;
            endcase
        end
        m_word <= mem[m_index];
    end

    rsmd5_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (rctl),
        .chain_in  (chain_reg),
        .m_word    (m_word),
        .m_index   (m_index),
        .done      (rnd_done),
        .chain_out (chain_new)
    );

    assign rctl.start = (state_reg == ST_CMP);
    assign rctl.busy  = (state_reg == ST_CWAIT);

    // Select the byte being written this cycle
    always_comb begin
        wr_en   = 1'b0;
        wr_byte = 8'h00;
        case (state_reg)
            ST_REC: begin
                wr_en   = 1'b1;
                wr_byte = rec_reg[199:192];
            end
            ST_PAD: begin
                wr_en   = 1'b1;
                wr_byte = pad_first_reg ? 8'h80 : 8'h00;
            end
            ST_LEN: begin
                wr_en   = 1'b1;
                wr_byte = bits_reg[7:0];
            end
            default: ;
        endcase
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        fill_next  = fill_reg;
        total_next = total_reg;
        count_next = count_reg;
        after_next = after_reg;
        case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    if (s_req_type[1]) begin
                        state_next = ST_REC;
                        cnt_next   = 5'd0;
                        count_next = count_reg + 32'd1;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_REC: begin
                fill_next  = fill_reg + 6'd1;
                total_next = total_reg + 61'd1;
                cnt_next   = cnt_reg + 5'd1;
                after_next = AFT_REC;
                if (fill_reg == 6'd63) begin
                    state_next = ST_CMP;
                end else if (cnt_reg == 5'd24) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CMP: state_next = ST_CWAIT;
            ST_CWAIT: begin
                if (rnd_done) begin
                    case (after_reg)
                        AFT_REC: state_next = (cnt_reg == 5'd25) ? ST_CHECK : ST_REC;
                        AFT_PAD: state_next = ST_PAD;
                        default: state_next = ST_OUT;
                    endcase
                end
            end
            ST_CHECK: state_next = last_reg ? ST_PAD : ST_IDLE;
            ST_PAD: begin
                fill_next  = fill_reg + 6'd1;
                after_next = AFT_PAD;
                if (fill_reg == 6'd63) begin
                    state_next = ST_CMP;
                end else if (fill_reg == 6'd55) begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN: begin
                fill_next  = fill_reg + 6'd1;
                after_next = AFT_LEN;
                if (fill_reg == 6'd63) begin
                    state_next = ST_CMP;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                    fill_next  = 6'd0;
                    total_next = 61'd0;
                    count_next = 32'd0;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 5'd0;
            fill_reg  <= 6'd0;
            total_reg <= 61'd0;
            count_reg <= 32'd0;
            after_reg <= AFT_REC;
            chain_reg <= CHAIN_INIT;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            fill_reg  <= fill_next;
            total_reg <= total_next;
            count_reg <= count_next;
            after_reg <= after_next;
            if (acc) begin
                last_reg <= s_last_item;
            end
            if (state_reg == ST_CWAIT && rnd_done) begin
                chain_reg <= chain_new;
            end else if (state_reg == ST_OUT && m_ready) begin
                chain_reg <= CHAIN_INIT;
            end
        end
    end

    // Record, padding and length shifters
    always_ff @(posedge aclk) begin
        if (acc) begin
            rec_reg <= {s_writer_system, s_writer_local, s_writer_serial,
                        s_write_seconds, s_write_nanos, s_sequence_number,
                        7'd0, (!s_has_instance || s_instance_no_writers)};
        end else if (state_reg == ST_REC) begin
            rec_reg <= {rec_reg[191:0], 8'h00};
        end
        if (state_reg == ST_CHECK) begin
            pad_first_reg <= 1'b1;
            bits_reg      <= {total_reg, 3'b000};
        end else if (state_reg == ST_PAD) begin
            pad_first_reg <= 1'b0;
        end else if (state_reg == ST_LEN) begin
            bits_reg <= {8'h00, bits_reg[63:8]};
        end
    end

    // Result: zero when no message was hashed
    assign m_valid        = (state_reg == ST_OUT);
    assign m_digest_flags = (count_reg != 32'd0);
    assign m_sample_count = count_reg;
    assign m_digest_high  = m_digest_flags ?
        {bswap(chain_reg[31:0]), bswap(chain_reg[63:32])} : 64'd0;
    assign m_digest_low   = m_digest_flags ?
        {bswap(chain_reg[95:64]), bswap(chain_reg[127:96])} : 64'd0;

endmodule

[hdl/rsmd5_round.sv]
// ============================================================================
// rsmd5_round: shared MD5 round unit
// Runs 64 rounds, one a cycle, over one block read word by word from memory.
// ============================================================================
module rsmd5_round import rsmd5_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  rsmd5_rnd_ctl_t ctl,
    input  logic [127:0]   chain_in,
    input  logic [31:0]    m_word,
    output logic [3:0]     m_index,
    output logic           done,
    output logic [127:0]   chain_out
);

    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] a_next, b_next, c_next, d_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic        run_reg, run_next;
    logic [31:0] f, t, rot;
    logic [5:0]  r;
    logic [4:0]  s;

    // Round index: counts 0..63 while running and rests at 64 when done; the word index is that of the next round
    assign r       = rnd_reg[5:0];
    assign m_index = run_reg ? md_g(6'(rnd_reg + 7'd1)) : md_g(6'd0);
    assign s       = md_s(r);

    always_comb begin
        case (r[5:4])
            2'd0: f = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1: f = (d_reg & b_reg) | (~d_reg & c_reg);
            2'd2: f = b_reg ^ c_reg ^ d_reg;
            default: f = c_reg ^ (b_reg | ~d_reg);
        endcase
        t   = a_reg + f + md_k(r) + m_word;
        rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
    end

    // Advance one round a cycle
    always_comb begin
        a_next = a_reg; b_next = b_reg; c_next = c_reg; d_next = d_reg;
        rnd_next = rnd_reg;
        run_next = run_reg;
        if (ctl.start) begin
            {d_next, c_next, b_next, a_next} = chain_in;
            rnd_next = 7'd0;
            run_next = 1'b1;
        end else if (run_reg) begin
            a_next = d_reg;
            d_next = c_reg;
            c_next = b_reg;
            b_next = b_reg + rot;
            rnd_next = rnd_reg + 7'd1;
            if (rnd_reg == 7'd63) begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            rnd_reg <= 7'd0;
        end else begin
            run_reg <= run_next;
            rnd_reg <= rnd_next;
        end
        a_reg <= a_next; b_reg <= b_next; c_reg <= c_next; d_reg <= d_next;
    end

    assign done = !run_reg && (rnd_reg == 7'd64) && ctl.busy;
    assign chain_out = {chain_in[127:96] + d_reg, chain_in[95:64] + c_reg,
                        chain_in[63:32] + b_reg, chain_in[31:0] + a_reg};

endmodule

[hdl/rsmd5_checker.sv]
// ============================================================================
// rsmd5_checker: port-level checks for the record-stream MD5 block
// Watches handshakes and result consistency on the top-level ports.
// ============================================================================
module rsmd5_checker import rsmd5_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_digest_flags,
    input logic [31:0] m_sample_count,
    input logic [63:0] m_digest_high,
    input logic [63:0] m_digest_low
);

    // Never be ready for an item while a result is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input ready while result pending");

    // Flag reflects a nonzero count
    a_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_digest_flags == (m_sample_count != 32'd0)))
        else $error("digest flag disagrees with count");

    // Empty digest is all zero
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_digest_flags) |-> (m_digest_high == 64'd0 && m_digest_low == 64'd0))
        else $error("nonzero digest without messages");

    // A stalled result holds: valid, high digest half and count stay stable
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_digest_high)
                                   && $stable(m_sample_count)))
        else $error("result changed while stalled");

endmodule

bind record_stream_md5_digest_unit rsmd5_checker u_rsmd5_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_digest_flags (m_digest_flags),
    .m_sample_count (m_sample_count),
    .m_digest_high  (m_digest_high),
    .m_digest_low   (m_digest_low)
);
